>>> rtl/core/rlap_pkg.sv
// ----------------------------------------------------------------------------
// rlap_pkg
// Shared types and constants of the record log append planner: request and
// result structs, operation codes, register indexes and controller links.
// ----------------------------------------------------------------------------
package rlap_pkg;

  // field widths
  localparam int ADDR_W    = 24;
  localparam int COUNT_W   = 12;
  localparam int PS_W      = 10;
  localparam int RB_W      = 13;
  localparam int CFG_IDX_W = 3;
  localparam int CAT_W     = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // operation codes
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_READ   = 2'd1,
    OP_SET    = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // category codes
  localparam logic [CAT_W-1:0] CAT_FAULT = 2'd0;
  localparam logic [CAT_W-1:0] CAT_ALARM = 2'd1;
  localparam logic [CAT_W-1:0] CAT_GAS   = 2'd2;
  localparam logic [CAT_W-1:0] CAT_OTHER = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FAULT_BASE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_BASE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAS_BASE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OTHER_BASE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PS_MAIN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PS_ALARM    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_SIZE = 3'd6;

  // register reset values
  localparam logic [ADDR_W-1:0] RST_FAULT_BASE  = 24'd0;
  localparam logic [ADDR_W-1:0] RST_ALARM_BASE  = 24'd16384;
  localparam logic [ADDR_W-1:0] RST_GAS_BASE    = 24'd36864;
  localparam logic [ADDR_W-1:0] RST_OTHER_BASE  = 24'd53248;
  localparam logic [PS_W-1:0]   RST_PS_MAIN     = 10'd500;
  localparam logic [PS_W-1:0]   RST_PS_ALARM    = 10'd400;
  localparam logic [RB_W-1:0]   RST_RECORD_SIZE = 13'd8;

  // request and result payloads
  typedef struct packed {
    op_t                operation;
    logic [CAT_W-1:0]   category;
    logic [COUNT_W-1:0] new_count;
  } in_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  write_addr;
    logic               compact;
    logic [COUNT_W-1:0] count_out;
    logic               status;
  } out_rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic cap;
    logic prep;
    logic div_step;
    logic mul_q;
    logic mul_r;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_append;
  } dp_sts_t;

endpackage

>>> rtl/core/record_log_append_planner.sv
// ----------------------------------------------------------------------------
// record_log_append_planner
// Keeps record counts of four flash log categories and plans the flash
// address of each appended record, flagging when the oldest sector is dropped.
// ----------------------------------------------------------------------------
//  channel   ports                              handshake
//  request   start, busy, in_data               start && !busy
//  result    out_valid, out_data                one-cycle strobe, no stall
//  config    cfg_valid, cfg_ready, cfg_index,   cfg_valid && cfg_ready
//            cfg_data
//
//  an append strobes its result after capture, prep, the 12-step
//  bit-serial divide by records per sector and the two products;
//  read, set and clear go from prep straight to the strobe
//  busy stays high through the strobe cycle, so the next request is
//  taken only once the block is back in idle
//  synchronous active-low reset restores register defaults and zero counts
//  cfg_ready is always high; results are taken the cycle they appear
// ----------------------------------------------------------------------------
module record_log_append_planner #(
  parameter int SECTORS_MAIN  = 4,
  parameter int SECTORS_ALARM = 5,
  parameter int SECTOR_BYTES  = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  rlap_pkg::in_req_t              in_data,
  output logic                           out_valid,
  output rlap_pkg::out_rsp_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rlap_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rlap_pkg::ADDR_W-1:0]    cfg_data
);
  import rlap_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  // sequencer
  rlap_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // datapath
  rlap_dp #(
    .SECTORS_MAIN  (SECTORS_MAIN),
    .SECTORS_ALARM (SECTORS_ALARM),
    .SECTOR_BYTES  (SECTOR_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

>>> rtl/core/rlap_ctrl.sv
// ----------------------------------------------------------------------------
// rlap_ctrl
// Sequencer of the planner: steps a request through capacity lookup, count
// update and, for an append, a bit-serial divide and the two address products.
// ----------------------------------------------------------------------------
module rlap_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  rlap_pkg::dp_sts_t sts,
  output rlap_pkg::dp_cmd_t cmd,
  output logic             busy,
  output logic             out_valid
);
  import rlap_pkg::*;

  localparam int STEP_W = $clog2(COUNT_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(COUNT_W - 1);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_CAP  = 7'b0000010,
    ST_PREP = 7'b0000100,
    ST_DIV  = 7'b0001000,
    ST_MULQ = 7'b0010000,
    ST_MULR = 7'b0100000,
    ST_RESP = 7'b1000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_CAP;
      end
      ST_CAP:  state_nxt = ST_PREP;
      ST_PREP: begin
        step_nxt  = '0;
        state_nxt = sts.is_append ? ST_DIV : ST_RESP;
      end
      ST_DIV: begin
        step_nxt = step_r + STEP_W'(1);
        if (step_r == LAST_STEP) state_nxt = ST_MULQ;
      end
      ST_MULQ: state_nxt = ST_MULR;
      ST_MULR: state_nxt = ST_RESP;
      ST_RESP: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // command decode
  always_comb begin
    cmd.load     = (state_r == ST_IDLE) && start;
    cmd.cap      = (state_r == ST_CAP);
    cmd.prep     = (state_r == ST_PREP);
    cmd.div_step = (state_r == ST_DIV);
    cmd.mul_q    = (state_r == ST_MULQ);
    cmd.mul_r    = (state_r == ST_MULR);
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_RESP);

endmodule

>>> rtl/core/rlap_dp.sv
// ----------------------------------------------------------------------------
// rlap_dp
// Datapath of the planner: configuration registers, the four record counts,
// a restoring divider by records per sector and the address accumulator.
// ----------------------------------------------------------------------------
module rlap_dp #(
  parameter int SECTORS_MAIN  = 4,
  parameter int SECTORS_ALARM = 5,
  parameter int SECTOR_BYTES  = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rlap_pkg::dp_cmd_t                cmd,
  output rlap_pkg::dp_sts_t                sts,
  input  rlap_pkg::in_req_t                in_data,
  output rlap_pkg::out_rsp_t               out_data,
  input  logic                             cfg_we,
  input  logic [rlap_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rlap_pkg::ADDR_W-1:0]      cfg_data
);
  import rlap_pkg::*;

  localparam int SEC_MAX = (SECTORS_MAIN > SECTORS_ALARM) ? SECTORS_MAIN : SECTORS_ALARM;
  localparam int SEC_W   = $clog2(SEC_MAX + 1);
  localparam int CAP_W   = SEC_W + PS_W;
  localparam int SB_W    = $clog2(SECTOR_BYTES + 1);
  localparam logic [SEC_W-1:0] SEC_MAIN_L  = SEC_W'(SECTORS_MAIN);
  localparam logic [SEC_W-1:0] SEC_ALARM_L = SEC_W'(SECTORS_ALARM);
  localparam logic [SB_W-1:0]  SB_L        = SB_W'(SECTOR_BYTES);

  // configuration registers
  logic [ADDR_W-1:0] fault_base_r, alarm_base_r, gas_base_r, other_base_r;
  logic [PS_W-1:0]   ps_main_r, ps_alarm_r;
  logic [RB_W-1:0]   rec_bytes_r;

  // working registers
  in_req_t            req_r;
  logic [PS_W-1:0]    ps_r;
  logic [COUNT_W-1:0] cap_r;
  logic [COUNT_W-1:0] cnt_r;
  logic [COUNT_W-1:0] quo_r;
  logic [PS_W-1:0]    rem_r;
  logic [ADDR_W-1:0]  acc_r;
  out_rsp_t           rsp_r;
  logic [COUNT_W-1:0] counts_r [4];

  // per sector count and capacity of the captured category
  logic [PS_W-1:0]    ps_sel;
  logic [SEC_W-1:0]   sec_sel;
  logic [CAP_W-1:0]   cap_prod;
  logic [COUNT_W-1:0] cap_nxt;

  always_comb begin
    ps_sel  = (req_r.category == CAT_ALARM) ? ps_alarm_r : ps_main_r;
    if (ps_sel == '0) ps_sel = PS_W'(1);
    sec_sel  = (req_r.category == CAT_ALARM) ? SEC_ALARM_L : SEC_MAIN_L;
    cap_prod = CAP_W'(sec_sel) * CAP_W'(ps_sel);
    cap_nxt  = (cap_prod > CAP_W'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(cap_prod);
  end

  // base address of the captured category
  logic [ADDR_W-1:0] base_sel;

  always_comb begin
    unique case (req_r.category)
      CAT_FAULT: base_sel = fault_base_r;
      CAT_ALARM: base_sel = alarm_base_r;
      CAT_GAS:   base_sel = gas_base_r;
      CAT_OTHER: base_sel = other_base_r;
      default:   base_sel = other_base_r;
    endcase
  end

  // append count after a possible compaction
  logic [COUNT_W-1:0] cur_cnt;
  logic               full;
  logic [COUNT_W-1:0] app_cnt;

  always_comb begin
    cur_cnt = counts_r[req_r.category];
    full    = (cur_cnt >= cap_r);
    if (!full) begin
      app_cnt = cur_cnt;
    end else if (cap_r >= COUNT_W'(ps_r)) begin
      app_cnt = cap_r - COUNT_W'(ps_r);
    end else begin
      app_cnt = '0;
    end
  end

  // one divide step
  logic [PS_W:0] rem_sh;
  logic          rem_ge;

  always_comb begin
    rem_sh = {rem_r, quo_r[COUNT_W-1]};
    rem_ge = (rem_sh >= {1'b0, ps_r});
  end

  // sector and slot offsets
  logic [COUNT_W+SB_W-1:0] q_prod;
  logic [PS_W+RB_W-1:0]    r_prod;

  assign q_prod = (COUNT_W+SB_W)'(quo_r) * (COUNT_W+SB_W)'(SB_L);
  assign r_prod = (PS_W+RB_W)'(rem_r) * (PS_W+RB_W)'(rec_bytes_r);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_base_r <= RST_FAULT_BASE;
      alarm_base_r <= RST_ALARM_BASE;
      gas_base_r   <= RST_GAS_BASE;
      other_base_r <= RST_OTHER_BASE;
      ps_main_r    <= RST_PS_MAIN;
      ps_alarm_r   <= RST_PS_ALARM;
      rec_bytes_r  <= RST_RECORD_SIZE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FAULT_BASE:  fault_base_r <= cfg_data;
        REG_ALARM_BASE:  alarm_base_r <= cfg_data;
        REG_GAS_BASE:    gas_base_r   <= cfg_data;
        REG_OTHER_BASE:  other_base_r <= cfg_data;
        REG_PS_MAIN:     ps_main_r    <= cfg_data[PS_W-1:0];
        REG_PS_ALARM:    ps_alarm_r   <= cfg_data[PS_W-1:0];
        REG_RECORD_SIZE: rec_bytes_r  <= cfg_data[RB_W-1:0];
        default: ;
      endcase
    end
  end

  // record counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) counts_r[i] <= '0;
    end else if (cmd.prep) begin
      case (req_r.operation)
        OP_SET:   counts_r[req_r.category] <= (req_r.new_count > cap_r) ? cap_r
                                                                        : req_r.new_count;
        OP_CLEAR: for (int i = 0; i < 4; i++) counts_r[i] <= '0;
        default: ;
      endcase
    end else if (cmd.mul_r) begin
      counts_r[req_r.category] <= cnt_r + COUNT_W'(1);
    end
  end

  // request processing
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (cmd.cap) begin
      ps_r  <= ps_sel;
      cap_r <= cap_nxt;
    end
    if (cmd.prep) begin
      rsp_r.write_addr <= '0;
      rsp_r.compact    <= (req_r.operation == OP_APPEND) && full;
      rsp_r.status     <= (req_r.operation == OP_SET) && (req_r.new_count > cap_r);
      cnt_r            <= app_cnt;
      quo_r            <= app_cnt;
      rem_r            <= '0;
      acc_r            <= base_sel;
      unique case (req_r.operation)
        OP_APPEND: ;
        OP_READ:   rsp_r.count_out <= cur_cnt;
        OP_SET:    rsp_r.count_out <= (req_r.new_count > cap_r) ? cap_r
                                                                : req_r.new_count;
        OP_CLEAR:  rsp_r.count_out <= '0;
        default: ;
      endcase
    end
    if (cmd.div_step) begin
      quo_r <= {quo_r[COUNT_W-2:0], rem_ge};
      rem_r <= rem_ge ? PS_W'(rem_sh - {1'b0, ps_r}) : PS_W'(rem_sh);
    end
    if (cmd.mul_q) begin
      acc_r <= acc_r + ADDR_W'(q_prod);
    end
    if (cmd.mul_r) begin
      rsp_r.write_addr <= acc_r + ADDR_W'(r_prod);
      rsp_r.count_out  <= cnt_r + COUNT_W'(1);
    end
  end

  assign sts.is_append = (req_r.operation == OP_APPEND);
  assign out_data      = rsp_r;

endmodule

>>> rtl/core/rlap_checker.sv
// ----------------------------------------------------------------------------
// rlap_checker
// Port-level checks of the planner: request and result sequencing and the
// consistency of the result flags.
// ----------------------------------------------------------------------------
module rlap_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input rlap_pkg::out_rsp_t out_data
);
  import rlap_pkg::*;

  // an accepted request makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accepted request");

  // a result only appears while a request is in flight
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe without request in flight");

  // one result per request, then idle
  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe longer than one cycle");

  // a clamped set never reports a compaction
  a_status_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> !out_data.compact)
    else $error("clamp and compaction flagged together");

endmodule

bind record_log_append_planner rlap_checker u_rlap_checker (.*);

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the record log append planner. A shadow planner
// tracks the four record counts and the register file, predicts each
// result on request accept, and a monitor compares every strobed result
// in order. Directed tests cover defaults, compaction, clamping, register
// extremes and counts above capacity; random traffic then runs under
// several register settings with random idle gaps on the request side.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rlap_pkg::*;

  localparam int SECTORS_MAIN  = 4;
  localparam int SECTORS_ALARM = 5;
  localparam int SECTOR_BYTES  = 4096;
  localparam int SETTLE_CYCLES = 24;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_req_t              in_data;
  logic                 out_valid;
  out_rsp_t             out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_data;

  // shadow register file and counts
  logic [ADDR_W-1:0]  base_addr [4];
  logic [PS_W-1:0]    ps_main;
  logic [PS_W-1:0]    ps_alarm;
  logic [RB_W-1:0]    rec_bytes;
  logic [COUNT_W-1:0] rec_count [4];

  out_rsp_t planned_q [$];
  int       mismatch_cnt;
  bit       idle_gaps;

  record_log_append_planner #(
    .SECTORS_MAIN (SECTORS_MAIN),
    .SECTORS_ALARM(SECTORS_ALARM),
    .SECTOR_BYTES (SECTOR_BYTES)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("record_log_append_planner verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // shadow planner
  // ---------------------------------------------------------------------------

  function automatic int unsigned cat_per_sector(logic [CAT_W-1:0] cat);
    int unsigned ps;
    ps = (cat == CAT_ALARM) ? ps_alarm : ps_main;
    return (ps == 0) ? 1 : ps;
  endfunction

  function automatic int unsigned cat_capacity(logic [CAT_W-1:0] cat);
    int unsigned sec;
    int unsigned cap;
    sec = (cat == CAT_ALARM) ? SECTORS_ALARM : SECTORS_MAIN;
    cap = sec * cat_per_sector(cat);
    return (cap > COUNT_MAX) ? COUNT_MAX : cap;
  endfunction

  function automatic void load_reset_regs();
    base_addr[0] = RST_FAULT_BASE;
    base_addr[1] = RST_ALARM_BASE;
    base_addr[2] = RST_GAS_BASE;
    base_addr[3] = RST_OTHER_BASE;
    ps_main      = RST_PS_MAIN;
    ps_alarm     = RST_PS_ALARM;
    rec_bytes    = RST_RECORD_SIZE;
    for (int i = 0; i < 4; i++) rec_count[i] = '0;
  endfunction

  function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                          logic [ADDR_W-1:0] data);
    case (idx)
      REG_FAULT_BASE:  base_addr[0] = data;
      REG_ALARM_BASE:  base_addr[1] = data;
      REG_GAS_BASE:    base_addr[2] = data;
      REG_OTHER_BASE:  base_addr[3] = data;
      REG_PS_MAIN:     ps_main      = data[PS_W-1:0];
      REG_PS_ALARM:    ps_alarm     = data[PS_W-1:0];
      REG_RECORD_SIZE: rec_bytes    = data[RB_W-1:0];
      default: ;
    endcase
  endfunction

  // predicts one result and advances the shadow counts
  function automatic out_rsp_t plan_record(in_req_t req);
    out_rsp_t        rsp;
    int unsigned     ps;
    int unsigned     cap;
    int unsigned     cnt;
    longint unsigned addr;
    rsp = '0;
    case (req.operation)
      OP_APPEND: begin
        ps  = cat_per_sector(req.category);
        cap = cat_capacity(req.category);
        cnt = rec_count[req.category];
        // full or over capacity: drop the oldest sector first
        if (cnt >= cap) begin
          rsp.compact = 1'b1;
          cnt = (cap >= ps) ? cap - ps : 0;
        end
        addr = longint'(base_addr[req.category])
             + longint'(cnt / ps) * SECTOR_BYTES
             + longint'(cnt % ps) * longint'(rec_bytes);
        rsp.write_addr = addr[ADDR_W-1:0];
        cnt = (cnt + 1) & COUNT_MAX;
        rec_count[req.category] = cnt[COUNT_W-1:0];
        rsp.count_out = cnt[COUNT_W-1:0];
      end
      OP_READ: rsp.count_out = rec_count[req.category];
      OP_SET: begin
        cap = cat_capacity(req.category);
        cnt = req.new_count;
        if (cnt > cap) begin
          cnt = cap;
          rsp.status = 1'b1;
        end
        rec_count[req.category] = cnt[COUNT_W-1:0];
        rsp.count_out = cnt[COUNT_W-1:0];
      end
      default: begin
        for (int i = 0; i < 4; i++) rec_count[i] = '0;
        rsp.count_out = '0;
      end
    endcase
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // result monitor
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    out_rsp_t want;
    if (rst_n && out_valid) begin
      if (planned_q.size() == 0) begin
        $error("result with no planned request: addr %0h count %0d",
               out_data.write_addr, out_data.count_out);
        mismatch_cnt++;
      end else begin
        want = planned_q.pop_front();
        if (out_data.write_addr !== want.write_addr) begin
          $error("write_addr mismatch: expected %0h actual %0h",
                 want.write_addr, out_data.write_addr);
          mismatch_cnt++;
        end
        if (out_data.compact !== want.compact) begin
          $error("compact mismatch: expected %0d actual %0d",
                 want.compact, out_data.compact);
          mismatch_cnt++;
        end
        if (out_data.count_out !== want.count_out) begin
          $error("count_out mismatch: expected %0d actual %0d",
                 want.count_out, out_data.count_out);
          mismatch_cnt++;
        end
        if (out_data.status !== want.status) begin
          $error("status mismatch: expected %0d actual %0d",
                 want.status, out_data.status);
          mismatch_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request and register drivers
  // ---------------------------------------------------------------------------

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one request: optional idle gap, then hold start until accepted
  task automatic send_req(in_req_t req);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
    planned_q.push_back(plan_record(req));
  endtask

  task automatic send_op(op_t op, logic [CAT_W-1:0] cat, int unsigned value);
    in_req_t req;
    req.operation = op;
    req.category  = cat;
    req.new_count = value[COUNT_W-1:0];
    send_req(req);
  endtask

  // stop issuing requests and let every planned result arrive
  task automatic wait_all_results();
    start <= 1'b0;
    while (planned_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg_write(idx, data);
  endtask

  // program the whole register file while the block is idle
  task automatic program_regs(logic [ADDR_W-1:0] fb, logic [ADDR_W-1:0] ab,
                              logic [ADDR_W-1:0] gb, logic [ADDR_W-1:0] ob,
                              logic [ADDR_W-1:0] psm, logic [ADDR_W-1:0] psa,
                              logic [ADDR_W-1:0] rb);
    wait_all_results();
    write_reg(REG_FAULT_BASE, fb);
    write_reg(REG_ALARM_BASE, ab);
    write_reg(REG_GAS_BASE, gb);
    write_reg(REG_OTHER_BASE, ob);
    write_reg(REG_PS_MAIN, psm);
    write_reg(REG_PS_ALARM, psa);
    write_reg(REG_RECORD_SIZE, rb);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset defaults, every operation, compaction and clamping
  task automatic test_default_plan();
    for (int c = 0; c < 4; c++) send_op(OP_READ, c[CAT_W-1:0], 0);
    for (int c = 0; c < 4; c++) send_op(OP_APPEND, c[CAT_W-1:0], 0);
    send_op(OP_SET, CAT_FAULT, COUNT_MAX);
    send_op(OP_APPEND, CAT_FAULT, 0);
    send_op(OP_SET, CAT_ALARM, 2000);
    send_op(OP_APPEND, CAT_ALARM, 4095);
    send_op(OP_SET, CAT_GAS, 0);
    send_op(OP_READ, CAT_GAS, 0);
    send_op(OP_SET, CAT_OTHER, 1999);
    send_op(OP_APPEND, CAT_OTHER, 0);
    send_op(OP_APPEND, CAT_OTHER, 0);
    send_op(OP_SET, CAT_GAS, 1500);
    send_op(OP_CLEAR, CAT_OTHER, 4095);
    for (int c = 0; c < 4; c++) send_op(OP_READ, c[CAT_W-1:0], 0);
  endtask

  // address wrap, zero and extreme per-sector and record sizes
  task automatic test_register_extremes();
    // top of address space, zero per-sector acts as one, zero record size
    program_regs(24'hFFFFFF, 24'hFFFFFF, 24'hFFF000, 24'hFFFFFF,
                 24'hFFFC00, 24'h000001, 24'hFFE000);
    for (int c = 0; c < 4; c++) begin
      send_op(OP_APPEND, c[CAT_W-1:0], 0);
      send_op(OP_SET, c[CAT_W-1:0], COUNT_MAX);
      send_op(OP_APPEND, c[CAT_W-1:0], 0);
    end
    // widest per-sector values push the alarm capacity past the count width
    program_regs(24'h000000, 24'h000000, 24'h800000, 24'h7FFFFF,
                 24'h0003FF, 24'hFFFFFF, 24'h001FFF);
    for (int c = 0; c < 4; c++) begin
      send_op(OP_SET, c[CAT_W-1:0], COUNT_MAX - 1);
      send_op(OP_APPEND, c[CAT_W-1:0], 0);
      send_op(OP_APPEND, c[CAT_W-1:0], 0);
    end
    // largest nominal sizes, and a write to an unused index
    program_regs(24'h123456, 24'h654321, 24'hABCDEF, 24'h0F0F0F,
                 24'd512, 24'd512, 24'd4096);
    write_reg(REG_UNUSED, 24'hFFFFFF);
    cfg_valid <= 1'b0;
    for (int c = 0; c < 4; c++) begin
      send_op(OP_SET, c[CAT_W-1:0], 4000);
      send_op(OP_APPEND, c[CAT_W-1:0], 0);
    end
  endtask

  // shrink per-sector size below the stored count, then append
  task automatic test_count_above_capacity();
    program_regs(24'h010000, 24'h020000, 24'h030000, 24'h040000,
                 24'd1000, 24'd900, 24'd16);
    for (int c = 0; c < 4; c++) send_op(OP_SET, c[CAT_W-1:0], 3999);
    program_regs(24'h010000, 24'h020000, 24'h030000, 24'h040000,
                 24'd3, 24'd7, 24'd16);
    for (int c = 0; c < 4; c++) begin
      send_op(OP_READ, c[CAT_W-1:0], 0);
      send_op(OP_APPEND, c[CAT_W-1:0], 0);
      send_op(OP_SET, c[CAT_W-1:0], 13);
    end
  endtask

  function automatic logic [ADDR_W-1:0] pick_ps();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return ADDR_W'($urandom_range(1, 8));
    if (r < 85) return ADDR_W'($urandom_range(0, 1023));
    if (r < 95) return (r[0] ? 24'd512 : 24'd0);
    return ADDR_W'($urandom());
  endfunction

  function automatic logic [ADDR_W-1:0] pick_base();
    if ($urandom_range(0, 9) == 0) return 24'hFFFFFF;
    return ADDR_W'($urandom());
  endfunction

  function automatic in_req_t pick_req();
    in_req_t     req;
    int unsigned r;
    int          near;
    r = $urandom_range(0, 99);
    if (r < 55)      req.operation = OP_APPEND;
    else if (r < 68) req.operation = OP_READ;
    else if (r < 93) req.operation = OP_SET;
    else             req.operation = OP_CLEAR;
    req.category = CAT_W'($urandom_range(0, 3));
    r = $urandom_range(0, 99);
    if (r < 40) begin
      req.new_count = COUNT_W'($urandom_range(0, 4095));
    end else if (r < 80) begin
      // land on or around the capacity so appends compact soon after
      near = int'(cat_capacity(req.category)) + int'($urandom_range(0, 4)) - 2;
      if (near < 0) near = 0;
      if (near > COUNT_MAX) near = COUNT_MAX;
      req.new_count = near[COUNT_W-1:0];
    end else begin
      req.new_count = COUNT_W'($urandom_range(0, 15));
    end
    return req;
  endfunction

  // random requests across several register settings
  task automatic test_random_traffic(int unsigned total);
    int unsigned per_phase;
    int unsigned pause_at;
    per_phase = total / 6;
    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        program_regs(pick_base(), pick_base(), pick_base(), pick_base(),
                     pick_ps(), pick_ps(),
                     ADDR_W'(($urandom_range(0, 3) == 0) ? $urandom() :
                                                           $urandom_range(0, 64)));
      end
      // one phase runs back to back with no idle gaps
      idle_gaps = (p != 2);
      pause_at  = $urandom_range(20, per_phase - 20);
      for (int i = 0; i < per_phase; i++) begin
        if (i == pause_at) wait_all_results();
        send_req(pick_req());
      end
    end
    idle_gaps = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    mismatch_cnt = 0;
    idle_gaps    = 1'b1;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    load_reset_regs();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_plan();
    test_register_extremes();
    test_count_above_capacity();
    test_random_traffic(1300);

    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("record_log_append_planner verification clean");
    end else begin
      $display("record_log_append_planner verification failed");
    end
    $finish;
  end

endmodule
